// ===== rtl/etc_pkg.sv =====
// Package: payload types, operation and result codes and defaults for the handle cache.
package etc_pkg;

  localparam int NUM_CLASSES_DEF = 8;
  localparam int CACHE_DEPTH_DEF = 8;
  localparam logic [3:0] FLUSH_BATCH_RST = 4'd4;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REFILL = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_REL   = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  sclass;
    logic [31:0] epoch;
    logic [63:0] handle;
    logic        slab_valid;
    logic [31:0] slab_epoch;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] handle_out;
    logic        ok;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] handle;
    logic [31:0] epoch;
  } entry_t;

endpackage

// ===== rtl/epoch_tagged_handle_cache.sv =====
// Top level: per-class LIFO handle stacks with epoch tags, run by a small sequencer.
//
// Usage: an operation is presented on in_data and taken at a clock edge where start
// is high and busy is low. busy then stays high until the final result is shown, and
// is low in that cycle. Results appear on out_data for one cycle each, marked by
// out_valid; out_data.last marks the final result of an operation. The receiver
// cannot stall. Alloc, free and refill each give one result; a free that finds its
// stack full first releases a batch. Flush walks every class over one read port
// of the entry memory, inspecting each entry and removing those whose tag matches
// the operation's epoch. The next operation can be taken once busy is low.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number of
// handles released when a free finds its stack full; it is always ready and must
// only be written while the block is idle. Reset empties every stack and sets
// the batch to four; the entry memory itself is not cleared, as slots above a
// stack's count are never read.
module epoch_tagged_handle_cache #(
  parameter int NUM_CLASSES = etc_pkg::NUM_CLASSES_DEF,
  parameter int CACHE_DEPTH = etc_pkg::CACHE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  etc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output etc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import etc_pkg::*;

  localparam int ENTRIES = NUM_CLASSES * CACHE_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CI_W    = $clog2(NUM_CLASSES + 1);
  localparam int CNT_W   = $clog2(CACHE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_DEC     = 8'b00000010,
    S_POP     = 8'b00000100,
    S_BAT_RD  = 8'b00001000,
    S_BAT_OUT = 8'b00010000,
    S_FL_RD   = 8'b00100000,
    S_FL_CHK  = 8'b01000000,
    S_FL_MV   = 8'b10000000
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           in_r;
  logic [3:0]         fb_r;
  logic [CNT_W-1:0]   cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_nxt [NUM_CLASSES];
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CI_W-1:0]    c_r, c_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [63:0]        pend_h_r, pend_h_nxt;
  logic               out_v_r, out_v_nxt;
  out_item_t          out_r, out_nxt;

  entry_t             mem [ENTRIES];
  entry_t             mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  entry_t             mem_wd;

  logic [CLS_W-1:0]   sc_idx, fc_idx;
  logic [CNT_W-1:0]   cur_cnt, fl_cnt;
  logic               sc_bad;
  logic [3:0]         fb_eff;

  function automatic logic [AW-1:0] slot_addr(input int cls, input int slot);
    slot_addr = AW'(cls * CACHE_DEPTH + slot);
  endfunction

  function automatic out_item_t mk_out(input logic [1:0] kind, input logic [63:0] h,
                                       input logic ok, input logic last);
    out_item_t o;
    o.kind       = kind;
    o.handle_out = h;
    o.ok         = ok;
    o.last       = last;
    mk_out = o;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign sc_idx  = in_r.sclass[CLS_W-1:0];
  assign fc_idx  = c_r[CLS_W-1:0];
  assign cur_cnt = cnt_r[sc_idx];
  assign fl_cnt  = cnt_r[fc_idx];
  assign sc_bad  = (32'(in_r.sclass) >= 32'(NUM_CLASSES));
  assign fb_eff  = (fb_r == 4'd0) ? 4'd1 : fb_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    c_nxt      = c_r;
    i_nxt      = i_r;
    pend_v_nxt = pend_v_r;
    pend_h_nxt = pend_h_r;
    out_v_nxt  = 1'b0;
    out_nxt    = out_r;
    mem_we     = 1'b0;
    mem_wa     = slot_addr(int'(sc_idx), int'(cur_cnt));
    mem_wd     = '{handle: in_r.handle, epoch: in_r.slab_epoch};
    mem_ra     = slot_addr(int'(sc_idx), int'(cur_cnt) - 1);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_IDLE;
        if (in_r.op == OP_FLUSH) begin
          c_nxt      = '0;
          i_nxt      = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_FL_RD;
        end else if (sc_bad) begin
          out_v_nxt = 1'b1;
          out_nxt   = mk_out((in_r.op == OP_ALLOC) ? KIND_ALLOC : KIND_ACK, 64'd0,
                             1'b0, 1'b1);
        end else if (in_r.op == OP_ALLOC) begin
          if (cur_cnt == '0) begin
            out_v_nxt = 1'b1;
            out_nxt   = mk_out(KIND_ALLOC, 64'd0, 1'b0, 1'b1);
          end else begin
            cnt_nxt[sc_idx] = cur_cnt - 1'b1;
            state_nxt       = S_POP;
          end
        end else if (32'(cur_cnt) < 32'(CACHE_DEPTH)) begin
          // Free with room pushes only a validated handle; refill always pushes.
          if (in_r.op == OP_FREE) begin
            mem_we    = in_r.slab_valid;
            out_nxt   = mk_out(KIND_ACK, 64'd0, in_r.slab_valid, 1'b1);
          end else begin
            mem_we    = 1'b1;
            mem_wd    = '{handle: in_r.handle, epoch: in_r.epoch};
            out_nxt   = mk_out(KIND_ACK, 64'd0, 1'b1, 1'b1);
          end
          if (mem_we) begin
            cnt_nxt[sc_idx] = cur_cnt + 1'b1;
          end
          out_v_nxt = 1'b1;
        end else if (in_r.op == OP_FREE) begin
          k_nxt     = (32'(fb_eff) > 32'(cur_cnt)) ? cur_cnt : CNT_W'(fb_eff);
          state_nxt = S_BAT_RD;
        end else begin
          out_v_nxt = 1'b1;
          out_nxt   = mk_out(KIND_ACK, 64'd0, 1'b0, 1'b1);
        end
      end

      S_POP: begin
        out_v_nxt = 1'b1;
        if (mem_q.epoch == in_r.epoch) begin
          out_nxt = mk_out(KIND_ALLOC, mem_q.handle, 1'b1, 1'b1);
        end else begin
          out_nxt = mk_out(KIND_ALLOC, 64'd0, 1'b0, 1'b1);
        end
        state_nxt = S_IDLE;
      end

      S_BAT_RD: begin
        if (k_r == '0) begin
          // Batch released: the freed handle goes on with a zero tag.
          mem_we          = 1'b1;
          mem_wd          = '{handle: in_r.handle, epoch: 32'd0};
          cnt_nxt[sc_idx] = cur_cnt + 1'b1;
          out_v_nxt       = 1'b1;
          out_nxt         = mk_out(KIND_ACK, 64'd0, 1'b1, 1'b1);
          state_nxt       = S_IDLE;
        end else begin
          cnt_nxt[sc_idx] = cur_cnt - 1'b1;
          k_nxt           = k_r - 1'b1;
          state_nxt       = S_BAT_OUT;
        end
      end

      S_BAT_OUT: begin
        out_v_nxt = 1'b1;
        out_nxt   = mk_out(KIND_REL, mem_q.handle, 1'b1, 1'b0);
        state_nxt = S_BAT_RD;
      end

      S_FL_RD: begin
        mem_ra = slot_addr(int'(fc_idx), int'(i_r));
        if (32'(c_r) >= 32'(NUM_CLASSES)) begin
          // The held release is the final one; with none, a plain ack.
          out_v_nxt  = 1'b1;
          out_nxt    = pend_v_r ? mk_out(KIND_REL, pend_h_r, 1'b1, 1'b1)
                                : mk_out(KIND_ACK, 64'd0, 1'b1, 1'b1);
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end else if (i_r >= fl_cnt) begin
          c_nxt = c_r + 1'b1;
          i_nxt = '0;
        end else begin
          state_nxt = S_FL_CHK;
        end
      end

      S_FL_CHK: begin
        mem_ra = slot_addr(int'(fc_idx), int'(fl_cnt) - 1);
        if (mem_q.epoch == in_r.epoch) begin
          // A match is held back one step so the last release can carry last.
          out_v_nxt       = pend_v_r;
          out_nxt         = mk_out(KIND_REL, pend_h_r, 1'b1, 1'b0);
          pend_v_nxt      = 1'b1;
          pend_h_nxt      = mem_q.handle;
          cnt_nxt[fc_idx] = fl_cnt - 1'b1;
          state_nxt       = S_FL_MV;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_FL_RD;
        end
      end

      S_FL_MV: begin
        mem_we    = 1'b1;
        mem_wa    = slot_addr(int'(fc_idx), int'(i_r));
        mem_wd    = mem_q;
        state_nxt = S_FL_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fb_r     <= FLUSH_BATCH_RST;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      k_r      <= '0;
      c_r      <= '0;
      i_r      <= '0;
      for (int n = 0; n < NUM_CLASSES; n++) begin
        cnt_r[n] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      k_r      <= k_nxt;
      c_r      <= c_nxt;
      i_r      <= i_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        fb_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    pend_h_r <= pend_h_nxt;
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("busy still high after final result");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not make the block busy");

  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_REL |-> out_data.ok)
    else $error("release result without ok");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

// ===== verif/tb_epoch_tagged_handle_cache.sv =====
// Testbench for the handle cache: directed and random operations checked against a local predictor.
module tb_epoch_tagged_handle_cache;
  import etc_pkg::*;

  localparam int NCLS  = 8;
  localparam int DEPTH = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  epoch_tagged_handle_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state, kept in step with the block.
  logic [3:0]  flush_len;
  int unsigned fill_level [NCLS];
  logic [63:0] cached_handle [NCLS][DEPTH];
  logic [31:0] cached_tag [NCLS][DEPTH];

  in_item_t  pending_ops [$];
  out_item_t expected_results [$];
  int        send_idle_pct;
  int        error_count = 0;
  int        ops_done = 0;
  int        results_seen = 0;
  int        releases_seen = 0;
  int        idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t mk_result(logic [1:0] kind, logic [63:0] h, logic ok,
                                          logic last);
    out_item_t r;
    r.kind = kind;
    r.handle_out = h;
    r.ok = ok;
    r.last = last;
    return r;
  endfunction

  task automatic predict_operation(input in_item_t it);
    int unsigned c;
    int unsigned i;
    int unsigned n;
    int unsigned top;
    int unsigned lim;
    c = it.sclass;
    n = 0;
    case (it.op)
      OP_FLUSH: begin
        for (int k = 0; k < NCLS; k++) begin
          i = 0;
          while (i < fill_level[k]) begin
            if (cached_tag[k][i] == it.epoch) begin
              expected_results.push_back(mk_result(KIND_REL, cached_handle[k][i], 1'b1, 1'b0));
              n++;
              fill_level[k]--;
              top = fill_level[k];
              cached_handle[k][i] = cached_handle[k][top];
              cached_tag[k][i] = cached_tag[k][top];
            end else begin
              i++;
            end
          end
        end
        if (n == 0) begin
          expected_results.push_back(mk_result(KIND_ACK, '0, 1'b1, 1'b1));
        end else begin
          expected_results[$].last = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (fill_level[c] > 0) begin
          fill_level[c]--;
          top = fill_level[c];
          if (cached_tag[c][top] == it.epoch) begin
            expected_results.push_back(mk_result(KIND_ALLOC, cached_handle[c][top], 1'b1, 1'b1));
          end else begin
            expected_results.push_back(mk_result(KIND_ALLOC, '0, 1'b0, 1'b1));
          end
        end else begin
          expected_results.push_back(mk_result(KIND_ALLOC, '0, 1'b0, 1'b1));
        end
      end
      OP_FREE: begin
        if (fill_level[c] < DEPTH) begin
          if (it.slab_valid) begin
            cached_handle[c][fill_level[c]] = it.handle;
            cached_tag[c][fill_level[c]] = it.slab_epoch;
            fill_level[c]++;
          end
          expected_results.push_back(mk_result(KIND_ACK, '0, it.slab_valid, 1'b1));
        end else begin
          // A zero batch still releases one so that the push finds room.
          lim = (flush_len == 0) ? 1 : flush_len;
          if (lim > fill_level[c]) lim = fill_level[c];
          for (int k = 0; k < lim; k++) begin
            fill_level[c]--;
            expected_results.push_back(mk_result(KIND_REL, cached_handle[c][fill_level[c]],
                                                 1'b1, 1'b0));
          end
          cached_handle[c][fill_level[c]] = it.handle;
          cached_tag[c][fill_level[c]] = '0;
          fill_level[c]++;
          expected_results.push_back(mk_result(KIND_ACK, '0, 1'b1, 1'b1));
        end
      end
      default: begin
        if (fill_level[c] < DEPTH) begin
          cached_handle[c][fill_level[c]] = it.handle;
          cached_tag[c][fill_level[c]] = it.epoch;
          fill_level[c]++;
          expected_results.push_back(mk_result(KIND_ACK, '0, 1'b1, 1'b1));
        end else begin
          expected_results.push_back(mk_result(KIND_ACK, '0, 1'b0, 1'b1));
        end
      end
    endcase
  endtask

  // Driver: offers the next pending operation, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_operation(in_data);
      ops_done <= ops_done + 1;
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data <= pending_ops.pop_front();
      start <= 1'b1;
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    int        errs;
    errs = 0;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (out_data.kind == KIND_REL) releases_seen <= releases_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d handle %h", out_data.kind,
               out_data.handle_out);
        errs++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_data.kind);
          errs++;
        end
        if (out_data.handle_out !== exp_r.handle_out) begin
          $error("handle_out: expected %h, got %h", exp_r.handle_out, out_data.handle_out);
          errs++;
        end
        if (out_data.ok !== exp_r.ok) begin
          $error("ok: expected %0d, got %0d", exp_r.ok, out_data.ok);
          errs++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_data.last);
          errs++;
        end
      end
      if (errs != 0) error_count <= error_count + errs;
    end
  end

  // Watchdog: counts cycles in which no transfer or result happens.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("epoch_tagged_handle_cache regression: fail");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_op(logic [1:0] op, logic [2:0] cls, logic [31:0] ep,
                                     logic [63:0] h, logic sv, logic [31:0] sep);
    in_item_t it;
    it.op = op;
    it.sclass = cls;
    it.epoch = ep;
    it.handle = h;
    it.slab_valid = sv;
    it.slab_epoch = sep;
    return it;
  endfunction

  // Epochs come from a small pool most of the time so that tags match often.
  function automatic logic [31:0] pick_epoch();
    case ($urandom_range(5))
      0: return {$urandom()};
      1: return 32'hFFFF_FFFF;
      2: return 32'h0;
      default: return $urandom_range(3);
    endcase
  endfunction

  task automatic queue_random(int count);
    in_item_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      it = mk_op(OP_ALLOC, 3'($urandom_range(7)), pick_epoch(), {$urandom(), $urandom()},
                 ($urandom_range(4) != 0), pick_epoch());
      if (r < 30) it.op = OP_FREE;
      else if (r < 60) it.op = OP_REFILL;
      else if (r < 92) it.op = OP_ALLOC;
      else it.op = OP_FLUSH;
      // Bias towards a few classes so that stacks fill up.
      if ($urandom_range(2) != 0) it.sclass = 3'($urandom_range(1));
      pending_ops.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_batch(logic [3:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    flush_len = value;
  endtask

  initial begin
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    send_idle_pct = 14;
    flush_len = FLUSH_BATCH_RST;
    foreach (fill_level[k]) fill_level[k] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty alloc, extreme fields, full stack on free and refill, flush.
    pending_ops.push_back(mk_op(OP_ALLOC, 3'd0, 32'h0, '0, 1'b0, 32'h0));
    pending_ops.push_back(mk_op(OP_FREE, 3'd7, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                                32'hFFFF_FFFF));
    pending_ops.push_back(mk_op(OP_ALLOC, 3'd7, 32'hFFFF_FFFF, '0, 1'b0, 32'h0));
    pending_ops.push_back(mk_op(OP_FREE, 3'd7, 32'h0, 64'h1234, 1'b0, 32'h5));
    pending_ops.push_back(mk_op(OP_REFILL, 3'd7, 32'h9, 64'hA5A5, 1'b0, 32'h0));
    pending_ops.push_back(mk_op(OP_ALLOC, 3'd7, 32'h8, '0, 1'b0, 32'h0));
    for (int k = 0; k < 9; k++)
      pending_ops.push_back(mk_op(OP_REFILL, 3'd1, k % 2, 64'h100 + k, 1'b1, 32'h0));
    pending_ops.push_back(mk_op(OP_FREE, 3'd1, 32'h0, 64'hBEEF, 1'b0, 32'h7));
    pending_ops.push_back(mk_op(OP_FLUSH, 3'd5, 32'h1, '0, 1'b0, 32'h0));
    pending_ops.push_back(mk_op(OP_FLUSH, 3'd0, 32'h77, '0, 1'b0, 32'h0));
    pending_ops.push_back(mk_op(OP_ALLOC, 3'd1, 32'h0, '0, 1'b0, 32'h0));
    wait_drained();

    write_batch(4'd8);
    queue_random(130);
    wait_drained();
    write_batch(4'd1);
    send_idle_pct = 53;
    queue_random(130);
    wait_drained();
    write_batch(4'd0);
    send_idle_pct = 0;
    queue_random(60);
    wait_drained();
    write_batch(4'd15);
    queue_random(71);
    wait_drained();

    $display("covered %0d operations, %0d results of which %0d releases to the backend",
             ops_done, results_seen, releases_seen);
    $display("flush batch sizes 4, 8, 1, 0 and 15 with sender idling 14%%, 53%% and 0%%");
    if (error_count == 0) begin
      $display("epoch_tagged_handle_cache regression: pass");
    end else begin
      $display("epoch_tagged_handle_cache regression: fail");
    end
    $finish;
  end
endmodule
